// ===== rtl/bresenham_line_rasterizer_core_assert.svh =====
// Assertion macros for the checker file of the rasterizer core.
// Both expect clk_i and rst_ni in scope and stay quiet while reset is held.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rasterizer core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rasterizer core: next-cycle check failed");

`endif

// ===== rtl/blr_pkg.sv =====
package blr_pkg;

  // Coordinate and dimension widths fixed by the interface.
  localparam int unsigned CoordW = 6;
  localparam int unsigned DimW   = 7;
  localparam int unsigned IndexW = 12;
  localparam int unsigned ColorW = 8;
  localparam int unsigned CfgIdxW = 1;

  // Signed error term of the stepper; wide enough for twice any error value.
  localparam int unsigned ErrW = 9;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT = 1'b1;

  // Input beat, first field in the lowest bits.
  typedef struct packed {
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic [CoordW-1:0] y_end;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_start;
  } in_beat_t;

  // Output beat data, first field in the lowest bits.
  typedef struct packed {
    logic [ColorW-1:0] out_blue;
    logic [ColorW-1:0] out_green;
    logic [ColorW-1:0] out_red;
    logic [IndexW-1:0] pixel_index;
    logic [CoordW-1:0] pixel_y;
    logic [CoordW-1:0] pixel_x;
  } out_beat_t;

  localparam int unsigned InTdataW  = $bits(in_beat_t);
  localparam int unsigned OutTdataW = $bits(out_beat_t);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // capture a new line from the input beat
    logic emit;  // register the current pixel and advance the stepper
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic at_end;    // current pixel equals the end point
    logic out_free;  // output register can take a pixel this cycle
  } dp_status_t;

endpackage

// ===== rtl/bresenham_line_rasterizer_core.sv =====
// Bresenham line rasterizer. Each input beat carries one line (start and end
// point on a 64 by 64 grid, plus an RGB color); the core walks the integer
// Bresenham stepper from start to end, both ends included, and sends one
// output beat per pixel, max(|dx|,|dy|)+1 beats in all, with tlast on the end
// point. Each pixel carries its linear index y*grid_width+x and, in tuser, a
// flag that is set when it lies inside the configured grid; outside pixels are
// still sent, with index zero. Grid width and height are written through the
// configuration channel (index 0 and 1) and saturate at GRID_SIZE; write them
// only while no line is in flight. The stepper produces one pixel per cycle
// while the output side keeps up; each line is first loaded from its input
// beat while the core is idle, and the next line is taken as soon as the end
// point has moved into the output register.
module bresenham_line_rasterizer_core #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [blr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [blr_pkg::DimW-1:0]           cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // x_start, y_start, x_end, y_end, red, green, blue
  input  logic [blr_pkg::InTdataW-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_x, pixel_y, pixel_index, out_red, out_green, out_blue
  output logic [blr_pkg::OutTdataW-1:0]      m_axis_tdata,
  // inside_res
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  blr_pkg::dp_cmd_t    cmd;
  blr_pkg::dp_status_t status;
  blr_pkg::in_beat_t   in_beat;
  blr_pkg::out_beat_t  out_beat;

  assign cfg_ready_o  = 1'b1;
  assign in_beat      = blr_pkg::in_beat_t'(s_axis_tdata);
  assign m_axis_tdata = out_beat;

  blr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  blr_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_beat_i    (in_beat),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_beat_o   (out_beat),
    .out_inside_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== rtl/blr_ctrl.sv =====
module blr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  blr_pkg::dp_status_t  status_i,
  output blr_pkg::dp_cmd_t     cmd_o
);

  blr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      blr_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = blr_pkg::StRun;
        end
      end
      blr_pkg::StRun: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.at_end) begin
            state_d = blr_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = blr_pkg::StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/blr_datapath.sv =====
module blr_datapath #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [blr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [blr_pkg::DimW-1:0]            cfg_data_i,
  input  blr_pkg::in_beat_t                   in_beat_i,
  input  blr_pkg::dp_cmd_t                    cmd_i,
  output blr_pkg::dp_status_t                 status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output blr_pkg::out_beat_t                  out_beat_o,
  output logic                                out_inside_o,
  output logic                                out_last_o
);

  localparam int unsigned CoordW = blr_pkg::CoordW;
  localparam int unsigned DimW   = blr_pkg::DimW;
  localparam int unsigned IndexW = blr_pkg::IndexW;
  localparam int unsigned ColorW = blr_pkg::ColorW;
  localparam int unsigned ErrW   = blr_pkg::ErrW;
  localparam int unsigned ProdW  = CoordW + DimW;
  localparam logic [DimW-1:0] GridDim = DimW'(GRID_SIZE);

  // Configuration registers, saturated to the grid size on write.
  logic [DimW-1:0] width_q, height_q, dim_clamped;

  assign dim_clamped = (cfg_data_i > GridDim) ? GridDim : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GridDim;
      height_q <= GridDim;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == blr_pkg::CFG_GRID_WIDTH) begin
        width_q <= dim_clamped;
      end
      if (cfg_index_i == blr_pkg::CFG_GRID_HEIGHT) begin
        height_q <= dim_clamped;
      end
    end
  end

  // Stepper registers.
  logic [CoordW-1:0]      x_q, y_q, xe_q, ye_q, x_d, y_d;
  logic [CoordW-1:0]      dx_q, dy_q, dx_ld, dy_ld;
  logic                   sx_q, sy_q;
  logic signed [ErrW-1:0] err_q, err_d, err_ld;
  logic signed [ErrW:0]   e2;
  logic signed [ErrW-1:0] dx_s, dy_s;
  logic                   step_x, step_y;
  logic [ColorW-1:0]      red_q, green_q, blue_q;

  assign dx_ld  = (in_beat_i.x_end > in_beat_i.x_start) ?
                  (in_beat_i.x_end - in_beat_i.x_start) : (in_beat_i.x_start - in_beat_i.x_end);
  assign dy_ld  = (in_beat_i.y_end > in_beat_i.y_start) ?
                  (in_beat_i.y_end - in_beat_i.y_start) : (in_beat_i.y_start - in_beat_i.y_end);
  assign err_ld = $signed({{(ErrW-CoordW){1'b0}}, dx_ld})
                - $signed({{(ErrW-CoordW){1'b0}}, dy_ld});

  assign dx_s   = $signed({{(ErrW-CoordW){1'b0}}, dx_q});
  assign dy_s   = $signed({{(ErrW-CoordW){1'b0}}, dy_q});
  assign e2     = {err_q, 1'b0};
  // Both tests may pass together; then the step is diagonal.
  assign step_x = e2 > -$signed({dy_s[ErrW-1], dy_s});
  assign step_y = e2 < $signed({dx_s[ErrW-1], dx_s});

  always_comb begin
    err_d = err_q;
    x_d   = x_q;
    y_d   = y_q;
    if (step_x) begin
      x_d = sx_q ? (x_q + 1'b1) : (x_q - 1'b1);
    end
    if (step_y) begin
      y_d = sy_q ? (y_q + 1'b1) : (y_q - 1'b1);
    end
    err_d = err_q - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= in_beat_i.x_start;
      y_q     <= in_beat_i.y_start;
      xe_q    <= in_beat_i.x_end;
      ye_q    <= in_beat_i.y_end;
      dx_q    <= dx_ld;
      dy_q    <= dy_ld;
      sx_q    <= in_beat_i.x_start < in_beat_i.x_end;
      sy_q    <= in_beat_i.y_start < in_beat_i.y_end;
      err_q   <= err_ld;
      red_q   <= in_beat_i.red;
      green_q <= in_beat_i.green;
      blue_q  <= in_beat_i.blue;
    end else if (cmd_i.emit) begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
  end

  // Clipping and linear index of the current pixel.
  logic              at_end, in_grid;
  logic [ProdW-1:0]  prod;
  logic [IndexW-1:0] index;

  assign at_end  = (x_q == xe_q) && (y_q == ye_q);
  assign in_grid = ({1'b0, x_q} < width_q) && ({1'b0, y_q} < height_q);
  assign prod    = {{DimW{1'b0}}, y_q} * {{CoordW{1'b0}}, width_q};
  assign index   = in_grid ? (prod[IndexW-1:0] + {{(IndexW-CoordW){1'b0}}, x_q}) : '0;

  // Output register; it takes a pixel whenever it is empty or being drained.
  logic out_valid_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.at_end   = at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_beat_o.pixel_x     <= x_q;
      out_beat_o.pixel_y     <= y_q;
      out_beat_o.pixel_index <= index;
      out_beat_o.out_red     <= red_q;
      out_beat_o.out_green   <= green_q;
      out_beat_o.out_blue    <= blue_q;
      out_inside_o           <= in_grid;
      out_last_o             <= at_end;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/blr_sva.sv =====
`include "bresenham_line_rasterizer_core_assert.svh"

module blr_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [blr_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  blr_pkg::out_beat_t out_beat;
  logic               in_fire;
  logic               line_open_q;

  assign out_beat = blr_pkg::out_beat_t'(m_axis_tdata);
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // A line is open from its input beat until its end point shows at the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_open_q <= 1'b0;
    end else if (in_fire) begin
      line_open_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tlast) begin
      line_open_q <= 1'b0;
    end
  end

  `BLR_ASSERT_SAME(a_one_line_at_a_time, in_fire,
                   !line_open_q || (m_axis_tvalid && m_axis_tlast))

  `BLR_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready)

  `BLR_ASSERT_SAME(a_clipped_index_zero, m_axis_tvalid && !m_axis_tuser,
                   out_beat.pixel_index == '0)

  `BLR_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind bresenham_line_rasterizer_core blr_sva u_blr_sva (.*);

// ===== tb/blr_pixel_checker.sv =====
// Watches the configuration, line and pixel channels of the rasterizer core.
// Every accepted line is expanded into its expected pixel beats, and every
// accepted pixel beat is compared with the oldest of them.
module blr_pixel_checker #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [blr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [blr_pkg::DimW-1:0]       cfg_data_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [blr_pkg::InTdataW-1:0]   s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [blr_pkg::OutTdataW-1:0]  m_tdata_i,
  input  logic                           m_tuser_i,
  input  logic                           m_tlast_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    pixels_checked_o
);

  typedef struct packed {
    blr_pkg::out_beat_t data;
    logic               in_grid;
    logic               last;
  } pixel_t;

  pixel_t expected_pixels[$];
  int unsigned grid_width = GRID_SIZE;
  int unsigned grid_height = GRID_SIZE;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    pixels_checked_o = 0;
  end

  function automatic int unsigned saturate_dim(logic [blr_pkg::DimW-1:0] value);
    return (value > GRID_SIZE) ? GRID_SIZE : int'(value);
  endfunction

  // Integer Bresenham walk with both error tests, so a tie steps diagonally.
  task automatic rasterize_line(blr_pkg::in_beat_t line);
    int x, y, xe, ye, dx, dy, sx, sy, err, e2;
    pixel_t px;
    x = line.x_start;
    y = line.y_start;
    xe = line.x_end;
    ye = line.y_end;
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;
    sx = (x < xe) ? 1 : -1;
    sy = (y < ye) ? 1 : -1;
    err = dx - dy;
    for (int n = 0; n < 64; n++) begin
      px.data.pixel_x = x[blr_pkg::CoordW-1:0];
      px.data.pixel_y = y[blr_pkg::CoordW-1:0];
      px.in_grid = (x < grid_width) && (y < grid_height);
      px.data.pixel_index = px.in_grid ? 12'(y * grid_width + x) : '0;
      px.data.out_red = line.red;
      px.data.out_green = line.green;
      px.data.out_blue = line.blue;
      px.last = (x == xe) && (y == ye);
      expected_pixels.push_back(px);
      if (px.last) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: pixel beat %0d field %s mismatch: expected 0x%0h, got 0x%0h",
               $time, pixels_checked_o, name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_pixel_beat();
    pixel_t want;
    blr_pkg::out_beat_t got;
    got = m_tdata_i;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected pixel beat: expected none, got x=%0d y=%0d",
               $time, got.pixel_x, got.pixel_y);
      fail_count_o++;
    end else begin
      want = expected_pixels.pop_front();
      compare_field("pixel_x", want.data.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.data.pixel_y, got.pixel_y);
      compare_field("pixel_index", want.data.pixel_index, got.pixel_index);
      compare_field("out_red", want.data.out_red, got.out_red);
      compare_field("out_green", want.data.out_green, got.out_green);
      compare_field("out_blue", want.data.out_blue, got.out_blue);
      compare_field("inside", want.in_grid, m_tuser_i);
      compare_field("last", want.last, m_tlast_i);
    end
    pixels_checked_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == blr_pkg::CFG_GRID_WIDTH) begin
          grid_width = saturate_dim(cfg_data_i);
        end else if (cfg_index_i == blr_pkg::CFG_GRID_HEIGHT) begin
          grid_height = saturate_dim(cfg_data_i);
        end
      end
      if (s_tvalid_i && s_tready_i) rasterize_line(s_tdata_i);
      if (m_tvalid_i && m_tready_i) check_pixel_beat();
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int unsigned GRID_SIZE = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned LINES_PER_PHASE = 52;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [blr_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [blr_pkg::DimW-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [blr_pkg::InTdataW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [blr_pkg::OutTdataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending_pixels;
  int unsigned pixels_checked;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned lines_sent = 0;
  int unsigned grid_writes = 0;

  bresenham_line_rasterizer_core #(
    .GRID_SIZE(GRID_SIZE)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  blr_pixel_checker #(
    .GRID_SIZE(GRID_SIZE)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tuser_i       (m_axis_tuser),
    .m_tlast_i       (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending_pixels),
    .pixels_checked_o(pixels_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Ends the run when no channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d pixels still expected",
                 $time, quiet_cycles, pending_pixels);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_line(blr_pkg::in_beat_t line);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= line;
    do @(posedge clk_i); while (!s_axis_tready);
    lines_sent++;
  endtask

  // Lowers valid and waits until every expected pixel has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_pixels != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [blr_pkg::CfgIdxW-1:0] index,
                            logic [blr_pkg::DimW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    grid_writes++;
  endtask

  function automatic blr_pkg::in_beat_t make_line(int xs, int ys, int xe, int ye,
                                                  logic [23:0] rgb);
    blr_pkg::in_beat_t line;
    line.x_start = xs[blr_pkg::CoordW-1:0];
    line.y_start = ys[blr_pkg::CoordW-1:0];
    line.x_end = xe[blr_pkg::CoordW-1:0];
    line.y_end = ye[blr_pkg::CoordW-1:0];
    {line.red, line.green, line.blue} = rgb;
    return line;
  endfunction

  function automatic int clip_coord(int v);
    return (v < 0) ? 0 : ((v > 63) ? 63 : v);
  endfunction

  // Mostly arbitrary lines, plus short, axis-aligned and diagonal ones.
  function automatic blr_pkg::in_beat_t random_line();
    int xs, ys, xe, ye, kind, span;
    xs = $urandom_range(63);
    ys = $urandom_range(63);
    xe = $urandom_range(63);
    ye = $urandom_range(63);
    kind = $urandom_range(9);
    if (kind >= 5 && kind <= 6) begin
      xe = clip_coord(xs + $urandom_range(6) - 3);
      ye = clip_coord(ys + $urandom_range(6) - 3);
    end else if (kind == 7) begin
      ye = ys;
    end else if (kind == 8) begin
      xe = xs;
    end else if (kind == 9) begin
      span = (xe > xs) ? xe - xs : xs - xe;
      if (ys + span <= 63) ye = ys + span;
      else if (ys - span >= 0) ye = ys - span;
    end
    return make_line(xs, ys, xe, ye, 24'($urandom));
  endfunction

  initial begin
    int widths[NUM_PHASES];
    int heights[NUM_PHASES];
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = blr_pkg::CFG_GRID_WIDTH;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    widths = '{127, 0, 1, 64, 40, 2, 0, 65};
    heights = '{127, 0, 1, 64, 25, 63, 0, 100};
    widths[6] = $urandom_range(1, 63);
    heights[6] = $urandom_range(1, 63);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines under the reset grid size.
    send_line(make_line(0, 0, 0, 0, 24'h000000));
    send_line(make_line(63, 63, 63, 63, 24'hffffff));
    send_line(make_line(0, 0, 63, 63, 24'hff0000));
    send_line(make_line(63, 63, 0, 0, 24'h00ff00));
    send_line(make_line(63, 0, 0, 63, 24'h0000ff));
    send_line(make_line(0, 63, 63, 0, 24'h55aa55));
    send_line(make_line(0, 5, 63, 5, 24'haa55aa));
    send_line(make_line(63, 40, 0, 40, 24'h123456));
    send_line(make_line(10, 0, 10, 63, 24'h654321));
    send_line(make_line(33, 63, 33, 0, 24'h0f0f0f));
    send_line(make_line(3, 2, 10, 60, 24'hf0f0f0));
    send_line(make_line(2, 3, 60, 10, 24'h808080));
    send_line(make_line(60, 10, 2, 3, 24'h7f7f7f));
    send_line(make_line(5, 5, 6, 7, 24'h010203));
    send_line(make_line(5, 5, 7, 6, 24'hfefdfc));
    send_line(make_line(20, 20, 21, 21, 24'hc3c3c3));
    send_line(make_line(0, 0, 63, 1, 24'h3c3c3c));
    send_line(make_line(0, 0, 1, 63, 24'h99cc33));
    send_line(make_line(62, 1, 63, 0, 24'h33cc99));
    send_line(make_line(0, 63, 62, 62, 24'hdeadbe));
    wait_drained();

    // Random phases; each writes a grid size and picks one of four flow control mixes.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_grid(blr_pkg::CFG_GRID_WIDTH, widths[phase][blr_pkg::DimW-1:0]);
      write_grid(blr_pkg::CFG_GRID_HEIGHT, heights[phase][blr_pkg::DimW-1:0]);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct = 27;
          recv_stall_pct = 27;
        end
      endcase
      for (int n = 0; n < LINES_PER_PHASE; n++) send_line(random_line());
      wait_drained();
    end

    $display("Rasterized %0d lines into %0d checked pixel beats, with %0d grid size writes",
             lines_sent, pixels_checked, grid_writes);
    $display("across four flow control mixes; %0d mismatches seen.", fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/blr_pkg.sv
rtl/blr_ctrl.sv
rtl/blr_datapath.sv
rtl/bresenham_line_rasterizer_core.sv
rtl/blr_sva.sv
tb/blr_pixel_checker.sv
tb/tb.sv
